### design/psvm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psvm_pkg: shared types and constants of the sine voice mixer
// Field layouts of the request and response words, voice records, sideband
// of the sine pipeline, codes and fixed-point constants.
// ----------------------------------------------------------------------------
package psvm_pkg;

   // bank size and sine resolution
   localparam int VOICES          = 32;
   localparam int SINE_TABLE_BITS = 10;
   localparam int VOICE_IDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int COUNT_W         = $clog2(VOICES + 1);

   // field widths
   localparam int SLOT_W     = 5;
   localparam int NOTE_W     = 7;
   localparam int PHASE_W    = 32;
   localparam int LEVEL_W    = 17;
   localparam int GAIN_W     = 17;
   localparam int PAN_W      = 16;
   localparam int SAMPLE_W   = 24;
   localparam int MASTER_W   = 18;
   localparam int COEFF_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   // datapath widths
   localparam int SINE_T_W   = 31;
   localparam int M_W        = 18;
   localparam int CONTRIB_W  = 19;
   localparam int ACC_W      = CONTRIB_W + VOICE_IDX_W + 2;
   localparam int MIX_W      = ACC_W + MASTER_W;
   localparam int SHIFT_W    = MIX_W - 9;

   // sequencing
   localparam int SINE_LAT     = 7;
   localparam int PAN_CYCLES   = SINE_LAT + 2;
   localparam int DRAIN_CYCLES = SINE_LAT + 6;
   localparam int STEP_W       = $clog2(VOICES + DRAIN_CYCLES + PAN_CYCLES + 1);

   // fixed-point constants
   localparam logic [GAIN_W-1:0] UNITY      = GAIN_W'(65536);
   localparam logic [GAIN_W-1:0] FREE_BELOW = GAIN_W'(66);
   localparam logic [SINE_T_W-1:0] Q30      = SINE_T_W'(1 << 30);
   localparam logic [29:0] PHASE_MASK =
      30'(~((64'd1 << (32 - SINE_TABLE_BITS)) - 64'd1));
   localparam logic [SHIFT_W-1:0] OUT_MAX_MAG = SHIFT_W'(8388607);
   localparam logic [SHIFT_W-1:0] OUT_MIN_MAG = SHIFT_W'(8388608);

   // odd polynomial of sin(pi/2 t) in Q30, Horner order
   localparam logic [31:0] SIN_C0 = 32'd172272;
   localparam logic [31:0] SIN_COEF [4] = '{32'd5026873, 32'd85569337,
                                             32'd693598343, 32'd1686629713};

   typedef enum logic [1:0] {
      MODE_TICK     = 2'd0,
      MODE_NOTE_ON  = 2'd1,
      MODE_NOTE_OFF = 2'd2,
      MODE_ALL_OFF  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASTER_GAIN   = 2'd0,
      CSR_ATTACK_COEFF  = 2'd1,
      CSR_RELEASE_COEFF = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAN,
      ST_SWEEP,
      ST_DRAIN,
      ST_MIX,
      ST_SAT
   } state_type;

   typedef enum logic [1:0] {
      SK_VOICE,
      SK_PAN_R,
      SK_PAN_L
   } side_kind_type;

   typedef struct packed {
      mode_type                  mode;
      logic [SLOT_W-1:0]         slot;
      logic [NOTE_W-1:0]         note;
      logic [PHASE_W-1:0]        phase_step;
      logic [LEVEL_W-1:0]        level;
      logic signed [PAN_W-1:0]   pan_position;
      logic                      end_of_block;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic [COUNT_W-1:0]         active_count;
      logic                       status;
   } rsp_type;

   typedef struct packed {
      logic active;
      logic releasing;
   } voice_ctrl_type;

   typedef struct packed {
      logic [NOTE_W-1:0]  note;
      logic [PHASE_W-1:0] phase;
      logic [PHASE_W-1:0] step;
      logic [LEVEL_W-1:0] level;
      logic [GAIN_W-1:0]  gain_l;
      logic [GAIN_W-1:0]  gain_r;
      logic [GAIN_W-1:0]  attack;
      logic [GAIN_W-1:0]  release_lvl;
   } voice_data_type;

   typedef struct packed {
      side_kind_type      kind;
      logic [LEVEL_W-1:0] level;
      logic [GAIN_W-1:0]  attack;
      logic [GAIN_W-1:0]  release_lvl;
      logic [GAIN_W-1:0]  gain_l;
      logic [GAIN_W-1:0]  gain_r;
   } side_type;

endpackage
`default_nettype wire

### design/psvm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psvm_cell: one voice cell of the rotating voice ring
// Holds one voice record and takes its neighbor's record on each shift.
// ----------------------------------------------------------------------------
module psvm_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift_en,
   input  psvm_pkg::voice_ctrl_type din_ctrl,
   input  psvm_pkg::voice_data_type din_data,
   output psvm_pkg::voice_ctrl_type dout_ctrl,
   output psvm_pkg::voice_data_type dout_data
);
   import psvm_pkg::*;

   voice_ctrl_type ctrl_ff;
   voice_data_type data_ff;

   // activity flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (shift_en) begin
         ctrl_ff <= din_ctrl;
      end
   end

   // voice payload
   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= din_data;
      end
   end

   assign dout_ctrl = ctrl_ff;
   assign dout_data = data_ff;

endmodule
`default_nettype wire

### design/psvm_sine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psvm_sine: pipelined quarter-wave sine evaluator
// Odd Horner polynomial in Q30, one multiply per stage, Q16 magnitude out.
// ----------------------------------------------------------------------------
module psvm_sine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [psvm_pkg::SINE_T_W-1:0]    in_t,
   input  logic                             in_neg,
   input  psvm_pkg::side_type               in_side,
   output logic                             out_valid,
   output logic [psvm_pkg::GAIN_W-1:0]      out_mag,
   output logic                             out_neg,
   output psvm_pkg::side_type               out_side
);
   import psvm_pkg::*;

   typedef struct packed {
      logic [SINE_T_W-1:0] t;
      logic [SINE_T_W-1:0] t2;
      logic [31:0]         p;
      logic                neg;
      side_type            side;
   } stage_type;

   logic [SINE_LAT-2:0] vld_ff;
   stage_type           stg_ff [SINE_LAT-1];
   stage_type           stg_in [SINE_LAT-1];
   logic                oval_ff;
   logic [GAIN_W-1:0]   mag_ff;
   logic                neg_ff;
   side_type            side_ff;

   logic [61:0]         sq;
   logic [62:0]         hprod [4];
   logic [62:0]         fprod;
   logic [32:0]         sraw;
   logic [32:0]         srnd;
   logic [GAIN_W-1:0]   mag_in;

   // stage math: square, four Horner steps, final scale
   always_comb begin
      stg_in[0]       = stg_ff[0];
      stg_in[0].t     = in_t;
      stg_in[0].neg   = in_neg;
      stg_in[0].side  = in_side;
      sq              = 62'(stg_ff[0].t) * 62'(stg_ff[0].t);
      stg_in[1]       = stg_ff[0];
      stg_in[1].t2    = sq[60:30];
      stg_in[1].p     = SIN_C0;
      for (int k = 0; k < 4; k++) begin
         hprod[k]       = 63'(stg_ff[k + 1].p) * 63'(stg_ff[k + 1].t2);
         stg_in[k + 2]   = stg_ff[k + 1];
         stg_in[k + 2].p = SIN_COEF[k] - hprod[k][61:30];
      end
      fprod = 63'(stg_ff[5].p) * 63'(stg_ff[5].t);
      sraw  = fprod[62:30];
      srnd  = (sraw + 33'd8192) >> 14;
      mag_in = (srnd > 33'(UNITY)) ? UNITY : srnd[GAIN_W-1:0];
   end

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         oval_ff <= 1'b0;
      end else begin
         vld_ff  <= {vld_ff[SINE_LAT-3:0], in_valid};
         oval_ff <= vld_ff[SINE_LAT-2];
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      for (int k = 0; k < SINE_LAT - 1; k++) begin
         stg_ff[k] <= stg_in[k];
      end
      mag_ff  <= mag_in;
      neg_ff  <= stg_ff[5].neg && (mag_in != '0);
      side_ff <= stg_ff[5].side;
   end

   assign out_valid = oval_ff;
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

### design/polyphonic_sine_voice_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_mixer: bank of sine voices with envelopes and pan
// Rotating ring of voice cells feeding a shared sine pipeline and mixer.
// ----------------------------------------------------------------------------
// Use:
//   req_valid/req_stall/req_data carry one command word: sample tick, note
//   on, note off or all notes off. rsp_valid/rsp_stall/rsp_data return one
//   word per command: stereo sample (zero for non-tick commands), number of
//   active voices and a miss flag for a note off with no matching voice.
//   csr_we/csr_index/csr_wdata write master gain, attack and release
//   coefficients; write them only while the block is idle.
// Timing:
//   every command rotates the voice ring once, one voice per cycle, then
//   drains the sine and product pipelines and runs the output scale; a
//   note on first runs its two pan gains through the sine pipeline.
//   One command is in flight at a time; the next is taken while the last
//   response still waits in the output register.
// Reset: all voices inactive, registers at their defaults, no response held.
// Stall: a held response blocks only the finish of the following command.
// ----------------------------------------------------------------------------
module polyphonic_sine_voice_mixer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  psvm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output psvm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [psvm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [psvm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import psvm_pkg::*;

   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   req_type                 item_ff;
   logic [MASTER_W-1:0]     master_ff;
   logic [COEFF_W-1:0]      acoeff_ff, rcoeff_ff;
   logic [GAIN_W-1:0]       gl_ff, gr_ff;
   logic                    found_ff, found_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic signed [ACC_W-1:0] accl_ff, accr_ff;
   logic [MIX_W-1:0]        mixl_ff, mixr_ff;
   logic                    negl_ff, negr_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    shift_en;
   logic                    load_rsp;
   logic [VOICE_IDX_W-1:0]  head_idx;

   voice_ctrl_type          ring_ctrl [VOICES];
   voice_data_type          ring_data [VOICES];
   voice_ctrl_type          nx_ctrl;
   voice_data_type          nx_data;

   logic                    sin_in_valid;
   logic [SINE_T_W-1:0]     sin_in_t;
   logic                    sin_in_neg;
   side_type                sin_in_side;
   logic                    sin_out_valid;
   logic [GAIN_W-1:0]       sin_out_mag;
   logic                    sin_out_neg;
   side_type                sin_out_side;

   // handshakes
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign shift_en  = (state_ff == ST_SWEEP);
   assign head_idx  = cnt_ff[VOICE_IDX_W-1:0];
   assign load_rsp  = (state_ff == ST_SAT) && (!rsp_valid_ff || !rsp_stall);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= MASTER_W'(65536);
         acoeff_ff <= COEFF_W'(65000);
         rcoeff_ff <= COEFF_W'(65000);
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MASTER_GAIN:   master_ff <= csr_wdata[MASTER_W-1:0];
            CSR_ATTACK_COEFF:  acoeff_ff <= csr_wdata[COEFF_W-1:0];
            CSR_RELEASE_COEFF: rcoeff_ff <= csr_wdata[COEFF_W-1:0];
            default: ;
         endcase
      end
   end

   // voice ring, head cell 0 feeds the update logic, tail takes the result
   for (genvar g = 0; g < VOICES; g++) begin : g_ring
      voice_ctrl_type cin_ctrl;
      voice_data_type cin_data;
      if (g == VOICES - 1) begin : g_tail
         assign cin_ctrl = nx_ctrl;
         assign cin_data = nx_data;
      end else begin : g_mid
         assign cin_ctrl = ring_ctrl[g + 1];
         assign cin_data = ring_data[g + 1];
      end
      psvm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .din_ctrl  (cin_ctrl),
         .din_data  (cin_data),
         .dout_ctrl (ring_ctrl[g]),
         .dout_data (ring_data[g])
      );
   end

   // head voice update for the current command
   logic [GAIN_W-1:0]    a_cap;
   logic [GAIN_W-1:0]    a_diff, c_diff;
   logic [33:0]          a_prod;
   logic [GAIN_W:0]      a_sum;
   logic [32:0]          r_prod;
   logic [GAIN_W-1:0]    r_new;
   logic                 slot_hit;
   logic [PAN_W-1:0]     pan_u;

   always_comb begin
      nx_ctrl  = ring_ctrl[0];
      nx_data  = ring_data[0];
      found_in = found_ff;
      a_cap    = (ring_data[0].attack > UNITY) ? UNITY : ring_data[0].attack;
      a_diff   = UNITY - a_cap;
      c_diff   = UNITY - GAIN_W'(acoeff_ff);
      a_prod   = 34'(a_diff) * 34'(c_diff);
      a_sum    = (GAIN_W + 1)'(a_cap) + a_prod[33:16];
      r_prod   = 33'(ring_data[0].release_lvl) * 33'(rcoeff_ff);
      r_new    = r_prod[32:16];
      slot_hit = (32'(item_ff.slot) == 32'(head_idx));
      unique case (item_ff.mode)
         MODE_TICK: begin
            if (ring_ctrl[0].active) begin
               nx_data.phase = ring_data[0].phase + ring_data[0].step;
               if (item_ff.end_of_block) begin
                  if (ring_ctrl[0].releasing) begin
                     nx_data.release_lvl = r_new;
                     if (r_new < FREE_BELOW) begin
                        nx_ctrl = '0;
                     end
                  end else begin
                     nx_data.attack = (a_sum > (GAIN_W + 1)'(UNITY)) ?
                                      UNITY : a_sum[GAIN_W-1:0];
                  end
               end
            end
         end
         MODE_NOTE_ON: begin
            if (slot_hit) begin
               nx_data.note        = item_ff.note;
               nx_data.step        = item_ff.phase_step;
               nx_data.level       = item_ff.level;
               nx_data.gain_l      = gl_ff;
               nx_data.gain_r      = gr_ff;
               nx_data.phase       = '0;
               nx_data.attack      = '0;
               nx_data.release_lvl = UNITY;
               nx_ctrl.active      = 1'b1;
               nx_ctrl.releasing   = 1'b0;
            end
         end
         MODE_NOTE_OFF: begin
            if (!found_ff && ring_ctrl[0].active &&
                ring_data[0].note == item_ff.note) begin
               nx_ctrl.releasing   = 1'b1;
               nx_data.release_lvl = UNITY;
               found_in            = 1'b1;
            end
         end
         MODE_ALL_OFF: begin
            nx_ctrl = '0;
         end
         default: ;
      endcase
      count_in = count_ff + COUNT_W'(nx_ctrl.active);
   end

   // sine requests: two pan gains for a note on, voice samples on a tick
   logic [29:0]         ph_r;
   logic [SINE_T_W-1:0] pan_t;

   always_comb begin
      pan_u       = item_ff.pan_position ^ 16'h8000;
      pan_t       = {1'b0, pan_u, 14'b0};
      ph_r        = ring_data[0].phase[29:0] & PHASE_MASK;
      sin_in_valid = 1'b0;
      sin_in_t     = '0;
      sin_in_neg   = 1'b0;
      sin_in_side  = '0;
      sin_in_side.level       = ring_data[0].level;
      sin_in_side.attack      = ring_data[0].attack;
      sin_in_side.release_lvl = ring_data[0].release_lvl;
      sin_in_side.gain_l      = ring_data[0].gain_l;
      sin_in_side.gain_r      = ring_data[0].gain_r;
      if (state_ff == ST_PAN && cnt_ff == STEP_W'(0)) begin
         sin_in_valid     = 1'b1;
         sin_in_t         = pan_t;
         sin_in_side.kind = SK_PAN_R;
      end else if (state_ff == ST_PAN && cnt_ff == STEP_W'(1)) begin
         sin_in_valid     = 1'b1;
         sin_in_t         = Q30 - pan_t;
         sin_in_side.kind = SK_PAN_L;
      end else if (state_ff == ST_SWEEP && item_ff.mode == MODE_TICK) begin
         sin_in_valid     = ring_ctrl[0].active;
         sin_in_t         = ring_data[0].phase[30] ? (Q30 - SINE_T_W'(ph_r))
                                                   : SINE_T_W'(ph_r);
         sin_in_neg       = ring_data[0].phase[31];
         sin_in_side.kind = SK_VOICE;
      end
   end

   psvm_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sin_in_valid),
      .in_t      (sin_in_t),
      .in_neg    (sin_in_neg),
      .in_side   (sin_in_side),
      .out_valid (sin_out_valid),
      .out_mag   (sin_out_mag),
      .out_neg   (sin_out_neg),
      .out_side  (sin_out_side)
   );

   // voice product chain: level, attack, release, then pan gains
   logic                 p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff;
   logic                 p1_n_ff, p2_n_ff, p3_n_ff, p4_n_ff;
   side_type             p1_s_ff, p2_s_ff, p3_s_ff;
   logic [M_W-1:0]       p1_m_ff, p2_m_ff, p3_m_ff;
   logic [CONTRIB_W-1:0] p4_l_ff, p4_r_ff;
   logic [33:0]          m1_prod;
   logic [34:0]          m2_prod, m3_prod, ml_prod, mr_prod;
   logic                 voice_out;

   assign voice_out = sin_out_valid && (sin_out_side.kind == SK_VOICE);
   assign m1_prod   = 34'(sin_out_mag) * 34'(sin_out_side.level);
   assign m2_prod   = 35'(p1_m_ff) * 35'(p1_s_ff.attack);
   assign m3_prod   = 35'(p2_m_ff) * 35'(p2_s_ff.release_lvl);
   assign ml_prod   = 35'(p3_m_ff) * 35'(p3_s_ff.gain_l);
   assign mr_prod   = 35'(p3_m_ff) * 35'(p3_s_ff.gain_r);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= voice_out;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_m_ff <= m1_prod[33:16];
      p1_n_ff <= sin_out_neg;
      p1_s_ff <= sin_out_side;
      p2_m_ff <= m2_prod[33:16];
      p2_n_ff <= p1_n_ff;
      p2_s_ff <= p1_s_ff;
      p3_m_ff <= m3_prod[33:16];
      p3_n_ff <= p2_n_ff;
      p3_s_ff <= p2_s_ff;
      p4_l_ff <= ml_prod[34:16];
      p4_r_ff <= mr_prod[34:16];
      p4_n_ff <= p3_n_ff;
   end

   // pan gain capture for a note on
   always_ff @(posedge clock) begin
      if (sin_out_valid && sin_out_side.kind == SK_PAN_R) begin
         gr_ff <= sin_out_mag;
      end
      if (sin_out_valid && sin_out_side.kind == SK_PAN_L) begin
         gl_ff <= sin_out_mag;
      end
   end

   // accumulators and output scale
   logic [ACC_W-1:0]    magl, magr;
   logic [SHIFT_W-1:0]  shl, shr;
   logic [SAMPLE_W-1:0] lowl, lowr;

   always_comb begin
      magl = accl_ff[ACC_W-1] ? ACC_W'(-accl_ff) : ACC_W'(accl_ff);
      magr = accr_ff[ACC_W-1] ? ACC_W'(-accr_ff) : ACC_W'(accr_ff);
      shl  = mixl_ff[MIX_W-1:9];
      shr  = mixr_ff[MIX_W-1:9];
      lowl = shl[SAMPLE_W-1:0];
      lowr = shr[SAMPLE_W-1:0];
      rsp_data_in = '0;
      if (negl_ff) begin
         rsp_data_in.left_sample = (shl > OUT_MIN_MAG) ? SAMPLE_W'(OUT_MIN_MAG) : -lowl;
      end else begin
         rsp_data_in.left_sample = (shl > OUT_MAX_MAG) ? SAMPLE_W'(OUT_MAX_MAG) : lowl;
      end
      if (negr_ff) begin
         rsp_data_in.right_sample = (shr > OUT_MIN_MAG) ? SAMPLE_W'(OUT_MIN_MAG) : -lowr;
      end else begin
         rsp_data_in.right_sample = (shr > OUT_MAX_MAG) ? SAMPLE_W'(OUT_MAX_MAG) : lowr;
      end
      rsp_data_in.active_count = count_ff;
      rsp_data_in.status       = (item_ff.mode == MODE_NOTE_OFF) && !found_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         accl_ff <= '0;
         accr_ff <= '0;
      end else if (p4_v_ff) begin
         accl_ff <= p4_n_ff ? accl_ff - ACC_W'(p4_l_ff) : accl_ff + ACC_W'(p4_l_ff);
         accr_ff <= p4_n_ff ? accr_ff - ACC_W'(p4_r_ff) : accr_ff + ACC_W'(p4_r_ff);
      end
      if (state_ff == ST_MIX) begin
         mixl_ff <= MIX_W'(magl) * MIX_W'(master_ff);
         mixr_ff <= MIX_W'(magr) * MIX_W'(master_ff);
         negl_ff <= accl_ff[ACC_W-1];
         negr_ff <= accr_ff[ACC_W-1];
      end
      if (accept) begin
         item_ff <= req_data;
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + STEP_W'(1);
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               state_in = (req_data.mode == MODE_NOTE_ON) ? ST_PAN : ST_SWEEP;
            end
         end
         ST_PAN: begin
            if (cnt_ff == STEP_W'(PAN_CYCLES - 1)) begin
               state_in = ST_SWEEP;
               cnt_in   = '0;
            end
         end
         ST_SWEEP: begin
            if (cnt_ff == STEP_W'(VOICES - 1)) begin
               state_in = ST_DRAIN;
               cnt_in   = '0;
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == STEP_W'(DRAIN_CYCLES - 1)) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (accept) begin
            found_ff <= 1'b0;
            count_ff <= '0;
         end else if (shift_en) begin
            found_ff <= found_in;
            count_ff <= count_in;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.active_count <= COUNT_W'(VOICES)))
      else $error("active count above bank size");

   a_quiet_non_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAT && item_ff.mode != MODE_TICK) |->
      (accl_ff == '0 && accr_ff == '0))
      else $error("non-tick command accumulated samples");

   a_sine_issue: assert property (@(posedge clock) disable iff (reset)
      sin_in_valid |-> (state_ff == ST_PAN || state_ff == ST_SWEEP))
      else $error("sine request outside pan or sweep");

   a_found_note_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && item_ff.mode != MODE_NOTE_OFF) |-> !found_ff)
      else $error("match flag set by a command other than note off");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!sin_out_valid && !p4_v_ff))
      else $error("pipeline still busy while idle");

endmodule
`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the polyphonic sine voice mixer
// A clocked driver sends command words from a pending queue. A clocked
// monitor predicts every accepted word with a bit-exact model of the voice
// bank. It then checks each response word against the oldest prediction.
// The run steps through several gain and envelope settings, the extremes
// among them, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   import psvm_pkg::*;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int SETTLE       = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   polyphonic_sine_voice_mixer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   req_type pending_words[$];
   rsp_type expected_words[$];
   int      cycle_count = 0;
   int      mismatch_count = 0;
   logic    word_taken = 1'b0;
   logic    steady = 1'b0;

   // append a word to the pending queue
   task automatic queue_word(input req_type w);
      pending_words.insert(pending_words.size(), w);
   endtask

   // mirror of the voice bank and its settings
   logic [17:0] m_master;
   logic [15:0] m_attack_k, m_release_k;
   logic        bank_on [VOICES];
   logic        bank_rel [VOICES];
   logic [6:0]  bank_note [VOICES];
   logic [31:0] bank_phase [VOICES];
   logic [31:0] bank_step [VOICES];
   logic [16:0] bank_level [VOICES];
   logic [15:0] bank_pan [VOICES];
   logic [16:0] bank_att [VOICES];
   logic [16:0] bank_relv [VOICES];

   // quarter-wave polynomial sine, magnitude in q16
   function automatic logic [16:0] sine_mag(input logic [31:0] ph, output logic neg);
      logic [63:0] t, t2, p, s;
      t  = ph[30] ? ((64'd1 << 30) - ph[29:0]) : 64'(ph[29:0]);
      t2 = (t * t) >> 30;
      p  = 64'd172272;
      p  = 64'd5026873 - ((p * t2) >> 30);
      p  = 64'd85569337 - ((p * t2) >> 30);
      p  = 64'd693598343 - ((p * t2) >> 30);
      p  = 64'd1686629713 - ((p * t2) >> 30);
      s  = (p * t) >> 30;
      s  = (s + 64'd8192) >> 14;
      if (s > 64'd65536) s = 64'd65536;
      neg = ph[31] && (s != 0);
      return s[16:0];
   endfunction

   // master scale and saturation
   function automatic logic [23:0] scale_out(input longint acc);
      logic [63:0] mag;
      longint      v;
      mag = (acc < 0) ? 64'(-acc) : 64'(acc);
      mag = (mag * m_master) >> 9;
      if (acc < 0) v = (mag > 64'd8388608) ? -64'sd8388608 : -longint'(mag);
      else v = (mag > 64'd8388607) ? 64'sd8388607 : longint'(mag);
      return v[23:0];
   endfunction

   // one command through the voice bank
   task automatic mix_voices(input req_type rq, output rsp_type rs);
      longint      acc_l, acc_r;
      logic        neg, dummy;
      logic [16:0] mag, gl, gr;
      logic [31:0] pu;
      logic [63:0] m;
      logic [31:0] a;
      int          n;
      acc_l = 0;
      acc_r = 0;
      rs = '0;
      case (rq.mode)
         MODE_TICK: begin
            for (int i = 0; i < VOICES; i++) begin
               if (!bank_on[i]) continue;
               mag = sine_mag(bank_phase[i] & 32'hFFC0_0000, neg);
               bank_phase[i] = bank_phase[i] + bank_step[i];
               pu = 32'(bank_pan[i] ^ 16'h8000);
               gr = sine_mag(pu << 14, dummy);
               gl = sine_mag(32'h4000_0000 - (pu << 14), dummy);
               m = (64'(mag) * bank_level[i]) >> 16;
               m = (m * bank_att[i]) >> 16;
               m = (m * bank_relv[i]) >> 16;
               if (neg) begin
                  acc_l -= longint'((m * gl) >> 16);
                  acc_r -= longint'((m * gr) >> 16);
               end else begin
                  acc_l += longint'((m * gl) >> 16);
                  acc_r += longint'((m * gr) >> 16);
               end
            end
            if (rq.end_of_block) begin
               for (int i = 0; i < VOICES; i++) begin
                  if (!bank_on[i]) continue;
                  if (bank_rel[i]) begin
                     bank_relv[i] = 17'((64'(bank_relv[i]) * m_release_k) >> 16);
                     if (bank_relv[i] < 17'd66) begin
                        bank_on[i] = 1'b0;
                        bank_rel[i] = 1'b0;
                     end
                  end else begin
                     a = (bank_att[i] > 17'd65536) ? 32'd65536 : 32'(bank_att[i]);
                     a = a + 32'((64'(32'd65536 - a) * (32'd65536 - m_attack_k)) >> 16);
                     bank_att[i] = (a > 32'd65536) ? 17'd65536 : a[16:0];
                  end
               end
            end
            rs.left_sample  = scale_out(acc_l);
            rs.right_sample = scale_out(acc_r);
         end
         MODE_NOTE_ON: begin
            bank_note[rq.slot]  = rq.note;
            bank_step[rq.slot]  = rq.phase_step;
            bank_level[rq.slot] = rq.level;
            bank_pan[rq.slot]   = rq.pan_position;
            bank_phase[rq.slot] = '0;
            bank_att[rq.slot]   = '0;
            bank_relv[rq.slot]  = 17'd65536;
            bank_rel[rq.slot]   = 1'b0;
            bank_on[rq.slot]    = 1'b1;
         end
         MODE_NOTE_OFF: begin
            rs.status = 1'b1;
            for (int i = 0; i < VOICES; i++) begin
               if (bank_on[i] && bank_note[i] == rq.note) begin
                  bank_rel[i] = 1'b1;
                  bank_relv[i] = 17'd65536;
                  rs.status = 1'b0;
                  break;
               end
            end
         end
         default: begin
            for (int i = 0; i < VOICES; i++) begin
               bank_on[i] = 1'b0;
               bank_rel[i] = 1'b0;
            end
         end
      endcase
      n = 0;
      for (int i = 0; i < VOICES; i++) if (bank_on[i]) n++;
      rs.active_count = COUNT_W'(n);
   endtask

   // driver: present words at the falling edge
   always @(negedge clock) begin
      if (!reset && (!req_valid || word_taken)) begin
         if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 11)) begin
            req_data  <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && !steady && ($urandom_range(99) < 11);
   end

   // monitor: predict accepted words and check responses
   always @(posedge clock) begin
      rsp_type predicted, want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         word_taken <= 1'b0;
         if (!reset && req_valid && !req_stall) begin
            mix_voices(req_data, predicted);
            expected_words.insert(expected_words.size(), predicted);
            word_taken <= 1'b1;
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) $display("unexpected word %h", rsp_data);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.left_sample !== want.left_sample ||
                   rsp_data.right_sample !== want.right_sample ||
                   rsp_data.active_count !== want.active_count ||
                   rsp_data.status !== want.status) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch exp L=%0d R=%0d n=%0d s=%0d got L=%0d R=%0d n=%0d s=%0d",
                        want.left_sample, want.right_sample, want.active_count, want.status,
                        rsp_data.left_sample, rsp_data.right_sample,
                        rsp_data.active_count, rsp_data.status);
               end
            end
         end
      end
   end

   function automatic req_type make_word(input mode_type md, input logic [4:0] sl,
                                         input logic [6:0] nt, input logic [31:0] st,
                                         input logic [16:0] lv, input logic [15:0] pn,
                                         input logic eob);
      req_type w;
      w.mode = md; w.slot = sl; w.note = nt; w.phase_step = st;
      w.level = lv; w.pan_position = pn; w.end_of_block = eob;
      return w;
   endfunction

   // random word, notes kept in a narrow band so note offs mostly hit
   function automatic req_type random_word();
      int          roll;
      logic [6:0]  nt;
      logic [31:0] st;
      roll = $urandom_range(99);
      nt = ($urandom_range(9) < 8) ? 7'($urandom_range(60, 67)) : 7'($urandom_range(127));
      st = ($urandom_range(1) != 0) ? $urandom() : 32'($urandom_range(4000000, 200000000));
      if (roll < 52)
         return make_word(MODE_TICK, 5'($urandom()), nt, $urandom(), 17'($urandom()),
                          16'($urandom()), 1'($urandom_range(99) < 60));
      else if (roll < 78)
         return make_word(MODE_NOTE_ON, 5'($urandom()), nt, st,
                          ($urandom_range(3) == 0) ? 17'($urandom()) :
                          17'($urandom_range(65536)), 16'($urandom()), 1'($urandom()));
      else if (roll < 98)
         return make_word(MODE_NOTE_OFF, 5'($urandom()), nt, $urandom(), 17'($urandom()),
                          16'($urandom()), 1'($urandom()));
      else
         return make_word(MODE_ALL_OFF, 5'($urandom()), nt, $urandom(), 17'($urandom()),
                          16'($urandom()), 1'($urandom()));
   endfunction

   // let every queued word finish, then a quiet spell
   task automatic drain_bank();
      while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MASTER_GAIN:  m_master = val;
         CSR_ATTACK_COEFF: m_attack_k = val[15:0];
         default:          m_release_k = val[15:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) queue_word(random_word());
      drain_bank();
   endtask

   initial begin
      m_master = 18'd65536;
      m_attack_k = 16'd65000;
      m_release_k = 16'd65000;
      for (int i = 0; i < VOICES; i++) begin
         bank_on[i] = 1'b0; bank_rel[i] = 1'b0; bank_note[i] = '0; bank_phase[i] = '0;
         bank_step[i] = '0; bank_level[i] = '0; bank_pan[i] = '0;
         bank_att[i] = '0; bank_relv[i] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners at reset settings
      queue_word(make_word(MODE_TICK, 5'd0, 7'd0, '0, '0, '0, 1'b1));
      queue_word(make_word(MODE_NOTE_OFF, 5'd0, 7'd40, '0, '0, '0, 1'b0));
      queue_word(make_word(MODE_NOTE_ON, 5'd0, 7'd0, 32'd0, 17'd0,
                           16'h8000, 1'b0));
      queue_word(make_word(MODE_NOTE_ON, 5'd31, 7'd127, 32'hFFFF_FFFF,
                           17'h1FFFF, 16'h7FFF, 1'b1));
      queue_word(make_word(MODE_NOTE_ON, 5'd5, 7'd127, 32'h0100_0000,
                           17'd65536, 16'h0000, 1'b0));
      queue_word(make_word(MODE_TICK, 5'd0, 7'd0, '0, '0, '0, 1'b0));
      queue_word(make_word(MODE_TICK, 5'd0, 7'd0, '0, '0, '0, 1'b1));
      queue_word(make_word(MODE_TICK, 5'd0, 7'd0, '0, '0, '0, 1'b1));
      // reload of an active slot
      queue_word(make_word(MODE_NOTE_ON, 5'd31, 7'd127, 32'h4000_0000,
                           17'd65536, 16'hC000, 1'b0));
      queue_word(make_word(MODE_TICK, 5'd0, 7'd0, '0, '0, '0, 1'b1));
      // note off, then again on the now releasing first match
      queue_word(make_word(MODE_NOTE_OFF, 5'd0, 7'd127, '0, '0, '0, 1'b0));
      queue_word(make_word(MODE_TICK, 5'd0, 7'd0, '0, '0, '0, 1'b1));
      queue_word(make_word(MODE_NOTE_OFF, 5'd0, 7'd127, '0, '0, '0, 1'b0));
      queue_word(make_word(MODE_TICK, 5'd0, 7'd0, '0, '0, '0, 1'b1));
      queue_word(make_word(MODE_NOTE_OFF, 5'd0, 7'd99, '0, '0, '0, 1'b1));
      queue_word(make_word(MODE_ALL_OFF, 5'd0, 7'd0, '0, '0, '0, 1'b0));
      queue_word(make_word(MODE_TICK, 5'd0, 7'd0, '0, '0, '0, 1'b1));
      drain_bank();

      random_phase(250);

      // loud extremes: full bank at full level, master 2.0, instant envelopes
      write_csr(CSR_MASTER_GAIN, 18'd131072);
      write_csr(CSR_ATTACK_COEFF, 16'd0);
      write_csr(CSR_RELEASE_COEFF, 16'd0);
      for (int i = 0; i < VOICES; i++)
         queue_word(make_word(MODE_NOTE_ON, 5'(i), 7'(i), 32'h0080_0000,
                              17'd65536, 16'($urandom()), 1'b0));
      for (int i = 0; i < 6; i++)
         queue_word(make_word(MODE_TICK, 5'd0, 7'd0, '0, '0, '0, 1'b1));
      steady = 1'b1;
      random_phase(250);
      steady = 1'b0;

      write_csr(CSR_ATTACK_COEFF, 16'd65535);
      write_csr(CSR_RELEASE_COEFF, 16'd65535);
      write_csr(CSR_MASTER_GAIN, 18'd0);
      random_phase(150);

      write_csr(CSR_MASTER_GAIN, 18'h3FFFF);
      random_phase(150);

      write_csr(CSR_MASTER_GAIN, 18'($urandom_range(131072)));
      write_csr(CSR_ATTACK_COEFF, 16'($urandom_range(20000, 60000)));
      write_csr(CSR_RELEASE_COEFF, 16'($urandom_range(20000, 50000)));
      random_phase(450);

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
design/psvm_pkg.sv
design/psvm_cell.sv
design/psvm_sine.sv
design/polyphonic_sine_voice_mixer.sv
sim/tb_top.sv
